// File: rtl/core/air_pkg.sv
// shared types, constants and helper functions for the assembly token lexer
package air_pkg;

	localparam int MATCH_CHARS = 8;
	localparam int MATCH_IDX_W = $clog2(MATCH_CHARS);
	localparam int OPCODE_COUNT = 41;
	localparam int OPC_IDX_W = $clog2(OPCODE_COUNT);
	localparam int OPC_MAX_LEN = 6;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_PCT = 8'h25;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_RBRACK = 8'h5d;
	localparam logic [7:0] CH_PLUS = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_STAR = 8'h2a;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_UNDER = 8'h5f;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] REG_MAX = 8'd254;
	localparam logic [31:0] PCT_VALUE = 32'd37;

	typedef enum logic [4:0] {
		KIND_OPCODE   = 5'd0,
		KIND_REG      = 5'd1,
		KIND_IDENT    = 5'd2,
		KIND_NUM      = 5'd3,
		KIND_COMMENT  = 5'd4,
		KIND_END      = 5'd5,
		KIND_UNKNOWN  = 5'd6,
		KIND_COMMA    = 5'd7,
		KIND_COLON    = 5'd8,
		KIND_LBRACKET = 5'd9,
		KIND_RBRACKET = 5'd10,
		KIND_PLUS     = 5'd11,
		KIND_MINUS    = 5'd12,
		KIND_MUL      = 5'd13,
		KIND_DIV      = 5'd14,
		KIND_SP       = 5'd15,
		KIND_MACRO    = 5'd16,
		KIND_STR      = 5'd17
	} kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_COMMENT = 3'd1,
		MODE_STRING  = 3'd2,
		MODE_NUMBER  = 3'd3,
		MODE_WORD    = 3'd4,
		MODE_PCT     = 3'd5
	} mode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_source;
	} src_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] line;
		logic [15:0] column;
		logic [31:0] start_offset;
		logic [15:0] token_length;
		logic [31:0] value;
		logic        unclosed;
		logic        last_of_run;
	} tok_item_t;

	typedef logic [7:0] match_buf_t [MATCH_CHARS];

	typedef struct packed {
		logic                 is_sp;
		logic                 is_entry;
		logic                 opc_hit;
		logic [OPC_IDX_W-1:0] opc_idx;
	} kw_match_t;

	localparam logic [OPC_MAX_LEN*8-1:0] OPC_TEXT [OPCODE_COUNT] = '{
		"add", "addi", "addm", "addr", "bge", "ble", "call", "cmp",
		"div", "divi", "divm", "divr", "je", "jg", "jge", "jl",
		"jle", "jmp", "jne", "mov", "movmi", "movmm", "movmr", "movri",
		"movrm", "movrr", "mul", "muli", "mulm", "mulr", "newi", "newstr",
		"popr", "print", "pushr", "ret", "sub", "subi", "subm", "subr",
		"vmcall"
	};

	localparam logic [2:0] OPC_LEN [OPCODE_COUNT] = '{
		3'd3, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3, 3'd4, 3'd3,
		3'd3, 3'd4, 3'd4, 3'd4, 3'd2, 3'd2, 3'd3, 3'd2,
		3'd3, 3'd3, 3'd3, 3'd3, 3'd5, 3'd5, 3'd5, 3'd5,
		3'd5, 3'd5, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd6,
		3'd4, 3'd5, 3'd5, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4,
		3'd6
	};

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'd48 && c <= 8'd57;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
	endfunction

endpackage

// File: rtl/core/air_if.sv
// stream interfaces for source bytes and tokens
interface air_src_if;
	logic                 valid;
	logic                 ready;
	air_pkg::src_item_t   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface air_tok_if;
	logic                 valid;
	logic                 ready;
	air_pkg::tok_item_t   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/air_kw_match.sv
// parallel keyword compare of the match buffer against sp, entry and the opcode rom
module air_kw_match (
	input  logic [7:0]          buf_data [air_pkg::MATCH_CHARS],
	input  logic [15:0]         word_len,
	input  logic [15:0]         pct_len,
	output air_pkg::kw_match_t  result
);

	localparam logic [15:0] SP_TEXT = "sp";
	localparam logic [39:0] ENTRY_TEXT = "entry";

	logic [air_pkg::OPCODE_COUNT-1:0] hit;

	always_comb begin
		for (int e = 0; e < air_pkg::OPCODE_COUNT; e++) begin
			hit[e] = (word_len == 16'(air_pkg::OPC_LEN[e]));
			for (int i = 0; i < air_pkg::OPC_MAX_LEN; i++) begin
				if (i < int'(air_pkg::OPC_LEN[e])) begin
					if (buf_data[i] != air_pkg::OPC_TEXT[e][8*(int'(air_pkg::OPC_LEN[e])-1-i) +: 8])
						hit[e] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		result.is_sp = (word_len == 16'd2) && (buf_data[0] == SP_TEXT[15:8])
			&& (buf_data[1] == SP_TEXT[7:0]);
		result.is_entry = (pct_len == 16'd5);
		for (int i = 0; i < 5; i++) begin
			if (buf_data[i] != ENTRY_TEXT[8*(4-i) +: 8])
				result.is_entry = 1'b0;
		end
		result.opc_hit = |hit;
		result.opc_idx = '0;
		for (int e = air_pkg::OPCODE_COUNT - 1; e >= 0; e--) begin
			if (hit[e])
				result.opc_idx = air_pkg::OPC_IDX_W'(e);
		end
	end

endmodule

// File: rtl/core/assembly_ir_tokenizer_core.sv
// top level of the assembly token lexer: byte scanner and token queue
//
// src carries one source byte per transfer, or an end-of-source marker.
// tok carries the tokens; each source transfer yields zero, one or two
// tokens, and last_of_run marks the final token of that transfer.
// A byte is scanned in the cycle of its transfer and its tokens are
// written into a four-entry token queue at the end of that cycle; they
// reach tok from the queue registers, behind any tokens already queued.
// Throughput is one byte per cycle, set by the single scan stage; src
// stays ready as long as the queue has room for two tokens, so a tok
// receiver that stalls fills the queue and then holds src back.
// End of source flushes any open token, emits END and returns all
// counters to line 1, column 1, offset 0 for the next source.
// Reset clears the scanner state and empties the queue.
module assembly_ir_tokenizer_core (
	input  logic        clk,
	input  logic        arst_n,
	air_src_if.sink     src,
	air_tok_if.source   tok
);

	localparam int CNT_W = air_pkg::OUT_PTR_W + 1;

	air_pkg::mode_t mode_q, mode_d;
	logic [15:0] cur_line_q, cur_line_d, cur_col_q, cur_col_d;
	logic [31:0] cur_off_q, cur_off_d;
	logic [15:0] tok_line_q, tok_line_d, tok_col_q, tok_col_d;
	logic [31:0] tok_off_q, tok_off_d;
	logic [15:0] tok_len_q, tok_len_d;
	logic [31:0] num_q, num_d;
	logic        regc_q, regc_d;
	logic [7:0]  rega_q, rega_d;
	logic [7:0]  match_q [air_pkg::MATCH_CHARS];
	logic        buf_we;
	logic [air_pkg::MATCH_IDX_W-1:0] buf_wa;

	air_pkg::kw_match_t kw;
	air_pkg::tok_item_t e0, ie, out0, out1;
	logic e0_v, ie_v, push0, push1;

	air_pkg::tok_item_t queue_q [air_pkg::OUT_DEPTH];
	logic [air_pkg::OUT_PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] count_q;
	logic fire, pop;

	logic [7:0]  c;
	logic [35:0] num_ext;
	logic [11:0] reg_ext;
	logic [15:0] pct_len;

	function automatic logic [15:0] inc16(input logic [15:0] v);
		return (v == 16'hffff) ? v : v + 16'd1;
	endfunction

	function automatic logic [31:0] inc32(input logic [31:0] v);
		return (v == 32'hffffffff) ? v : v + 32'd1;
	endfunction

	assign c = src.data.ch;
	assign pct_len = tok_len_q - 16'd1;
	assign fire = src.valid && src.ready;
	assign src.ready = count_q <= CNT_W'(air_pkg::OUT_DEPTH - 2);
	assign pop = tok.valid && tok.ready;
	assign tok.valid = count_q != '0;
	assign tok.data = queue_q[rp_q];
	assign num_ext = ({4'd0, num_q} * 36'd10) + {28'd0, c - air_pkg::CH_ZERO};
	assign reg_ext = ({4'd0, rega_q} * 12'd10) + {4'd0, c - air_pkg::CH_ZERO};

	air_kw_match u_kw (
		.buf_data (match_q),
		.word_len (tok_len_q),
		.pct_len  (pct_len),
		.result   (kw)
	);

	always_comb begin
		air_pkg::tok_item_t wr;
		logic done;
		wr = '0;
		wr.line = tok_line_q;
		wr.column = tok_col_q;
		wr.start_offset = tok_off_q;
		wr.token_length = tok_len_q;
		if (kw.is_sp) begin
			wr.kind = air_pkg::KIND_SP;
		end else if (regc_q && tok_len_q >= 16'd2 && rega_q <= air_pkg::REG_MAX) begin
			wr.kind = air_pkg::KIND_REG;
			wr.value = {24'd0, rega_q};
		end else if (kw.opc_hit) begin
			wr.kind = air_pkg::KIND_OPCODE;
			wr.value = 32'(kw.opc_idx);
		end else begin
			wr.kind = air_pkg::KIND_IDENT;
		end

		done = 1'b0;
		mode_d = mode_q;
		cur_line_d = cur_line_q;
		cur_col_d = cur_col_q;
		cur_off_d = cur_off_q;
		tok_line_d = tok_line_q;
		tok_col_d = tok_col_q;
		tok_off_d = tok_off_q;
		tok_len_d = tok_len_q;
		num_d = num_q;
		regc_d = regc_q;
		rega_d = rega_q;
		buf_we = 1'b0;
		buf_wa = '0;
		e0_v = 1'b0;
		e0 = '0;
		e0.line = tok_line_q;
		e0.column = tok_col_q;
		e0.start_offset = tok_off_q;
		e0.token_length = tok_len_q;
		ie_v = 1'b0;
		ie = '0;
		ie.line = cur_line_q;
		ie.column = cur_col_q;
		ie.start_offset = cur_off_q;
		ie.token_length = 16'd1;

		if (src.data.end_of_source) begin
			unique case (mode_q)
				air_pkg::MODE_COMMENT: begin
					e0_v = 1'b1;
					e0.kind = air_pkg::KIND_COMMENT;
				end
				air_pkg::MODE_STRING: begin
					e0_v = 1'b1;
					e0.kind = air_pkg::KIND_STR;
					e0.unclosed = 1'b1;
				end
				air_pkg::MODE_NUMBER: begin
					e0_v = 1'b1;
					e0.kind = air_pkg::KIND_NUM;
					e0.value = num_q;
				end
				air_pkg::MODE_WORD: begin
					e0_v = 1'b1;
					e0 = wr;
				end
				air_pkg::MODE_PCT: begin
					e0_v = 1'b1;
					if (kw.is_entry) begin
						e0.kind = air_pkg::KIND_MACRO;
					end else begin
						e0.kind = air_pkg::KIND_UNKNOWN;
						e0.value = air_pkg::PCT_VALUE;
					end
				end
				default: begin
					e0_v = 1'b0;
				end
			endcase
			ie_v = 1'b1;
			ie.kind = air_pkg::KIND_END;
			ie.token_length = 16'd0;
			mode_d = air_pkg::MODE_IDLE;
			cur_line_d = 16'd1;
			cur_col_d = 16'd1;
			cur_off_d = '0;
			tok_line_d = 16'd1;
			tok_col_d = 16'd1;
			tok_off_d = '0;
			tok_len_d = '0;
			num_d = '0;
			regc_d = 1'b0;
			rega_d = '0;
		end else begin
			unique case (mode_q)
				air_pkg::MODE_COMMENT: begin
					if (c == air_pkg::CH_LF) begin
						e0_v = 1'b1;
						e0.kind = air_pkg::KIND_COMMENT;
						mode_d = air_pkg::MODE_IDLE;
					end else begin
						done = 1'b1;
					end
				end
				air_pkg::MODE_STRING: begin
					if (c == air_pkg::CH_QUOTE) begin
						done = 1'b1;
						e0_v = 1'b1;
						e0.kind = air_pkg::KIND_STR;
						e0.token_length = inc16(tok_len_q);
						mode_d = air_pkg::MODE_IDLE;
					end else if (c == air_pkg::CH_LF) begin
						e0_v = 1'b1;
						e0.kind = air_pkg::KIND_STR;
						e0.unclosed = 1'b1;
						mode_d = air_pkg::MODE_IDLE;
					end else begin
						done = 1'b1;
					end
				end
				air_pkg::MODE_NUMBER: begin
					if (air_pkg::is_digit(c)) begin
						done = 1'b1;
						num_d = (num_ext > 36'hffffffff) ? 32'hffffffff : num_ext[31:0];
					end else begin
						e0_v = 1'b1;
						e0.kind = air_pkg::KIND_NUM;
						e0.value = num_q;
						mode_d = air_pkg::MODE_IDLE;
					end
				end
				air_pkg::MODE_WORD: begin
					if (air_pkg::is_alpha(c) || air_pkg::is_digit(c) || c == air_pkg::CH_UNDER) begin
						done = 1'b1;
						buf_we = tok_len_q < 16'(air_pkg::MATCH_CHARS);
						buf_wa = tok_len_q[air_pkg::MATCH_IDX_W-1:0];
						if (regc_q && air_pkg::is_digit(c))
							rega_d = (reg_ext > 12'd255) ? 8'd255 : reg_ext[7:0];
						else
							regc_d = 1'b0;
					end else begin
						e0_v = 1'b1;
						e0 = wr;
						mode_d = air_pkg::MODE_IDLE;
					end
				end
				air_pkg::MODE_PCT: begin
					if (!air_pkg::is_space(c)) begin
						done = 1'b1;
						buf_we = pct_len < 16'(air_pkg::MATCH_CHARS);
						buf_wa = pct_len[air_pkg::MATCH_IDX_W-1:0];
					end else if (kw.is_entry) begin
						e0_v = 1'b1;
						e0.kind = air_pkg::KIND_MACRO;
						mode_d = air_pkg::MODE_IDLE;
					end else begin
						done = 1'b1;
						e0_v = 1'b1;
						e0.kind = air_pkg::KIND_UNKNOWN;
						e0.value = air_pkg::PCT_VALUE;
						e0.token_length = inc16(tok_len_q);
						mode_d = air_pkg::MODE_IDLE;
					end
				end
				default: begin
					mode_d = air_pkg::MODE_IDLE;
				end
			endcase

			if (done) begin
				cur_off_d = inc32(cur_off_q);
				cur_col_d = inc16(cur_col_q);
				tok_len_d = inc16(tok_len_q);
			end else if (air_pkg::is_space(c)) begin
				cur_off_d = inc32(cur_off_q);
				if (c == air_pkg::CH_LF) begin
					cur_line_d = inc16(cur_line_q);
					cur_col_d = 16'd1;
				end else begin
					cur_col_d = inc16(cur_col_q);
				end
			end else begin
				tok_line_d = cur_line_q;
				tok_col_d = cur_col_q;
				tok_off_d = cur_off_q;
				tok_len_d = 16'd1;
				cur_off_d = inc32(cur_off_q);
				cur_col_d = inc16(cur_col_q);
				ie_v = 1'b1;
				priority case (1'b1)
					c == air_pkg::CH_HASH: begin
						ie_v = 1'b0;
						mode_d = air_pkg::MODE_COMMENT;
					end
					c == air_pkg::CH_QUOTE: begin
						ie_v = 1'b0;
						mode_d = air_pkg::MODE_STRING;
					end
					c == air_pkg::CH_COMMA: ie.kind = air_pkg::KIND_COMMA;
					c == air_pkg::CH_COLON: ie.kind = air_pkg::KIND_COLON;
					c == air_pkg::CH_LBRACK: ie.kind = air_pkg::KIND_LBRACKET;
					c == air_pkg::CH_RBRACK: ie.kind = air_pkg::KIND_RBRACKET;
					c == air_pkg::CH_PLUS: ie.kind = air_pkg::KIND_PLUS;
					c == air_pkg::CH_MINUS: ie.kind = air_pkg::KIND_MINUS;
					c == air_pkg::CH_STAR: ie.kind = air_pkg::KIND_MUL;
					c == air_pkg::CH_SLASH: ie.kind = air_pkg::KIND_DIV;
					c == air_pkg::CH_PCT: begin
						ie_v = 1'b0;
						mode_d = air_pkg::MODE_PCT;
					end
					air_pkg::is_digit(c): begin
						ie_v = 1'b0;
						mode_d = air_pkg::MODE_NUMBER;
						num_d = {24'd0, c - air_pkg::CH_ZERO};
					end
					air_pkg::is_alpha(c): begin
						ie_v = 1'b0;
						mode_d = air_pkg::MODE_WORD;
						buf_we = 1'b1;
						buf_wa = '0;
						regc_d = c == air_pkg::CH_R;
						rega_d = '0;
					end
					default: begin
						ie.kind = air_pkg::KIND_UNKNOWN;
						ie.value = {24'd0, c};
					end
				endcase
			end
		end

		out0 = e0_v ? e0 : ie;
		out1 = ie;
		out0.last_of_run = !(e0_v && ie_v);
		out1.last_of_run = 1'b1;
		push0 = fire && (e0_v || ie_v);
		push1 = fire && e0_v && ie_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= air_pkg::MODE_IDLE;
			cur_line_q <= 16'd1;
			cur_col_q <= 16'd1;
			cur_off_q <= '0;
			tok_line_q <= 16'd1;
			tok_col_q <= 16'd1;
			tok_off_q <= '0;
			tok_len_q <= '0;
			num_q <= '0;
			regc_q <= 1'b0;
			rega_q <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			cur_line_q <= cur_line_d;
			cur_col_q <= cur_col_d;
			cur_off_q <= cur_off_d;
			tok_line_q <= tok_line_d;
			tok_col_q <= tok_col_d;
			tok_off_q <= tok_off_d;
			tok_len_q <= tok_len_d;
			num_q <= num_d;
			regc_q <= regc_d;
			rega_q <= rega_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && buf_we)
			match_q[buf_wa] <= c;
	end

	always_ff @(posedge clk) begin
		if (push0)
			queue_q[wp_q] <= out0;
		if (push1)
			queue_q[wp_q + air_pkg::OUT_PTR_W'(1)] <= out1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			count_q <= '0;
		end else begin
			wp_q <= wp_q + air_pkg::OUT_PTR_W'(push0) + air_pkg::OUT_PTR_W'(push1);
			if (pop)
				rp_q <= rp_q + air_pkg::OUT_PTR_W'(1);
			count_q <= count_q + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);
		end
	end

`ifndef SYNTHESIS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(air_pkg::OUT_DEPTH))
		else $error("token queue overflow");

	a_full_stalls_src: assert property (@(posedge clk) disable iff (!arst_n)
		count_q > CNT_W'(air_pkg::OUT_DEPTH - 2) |-> !src.ready)
		else $error("source taken without queue room");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		tok.valid && tok.data.kind == air_pkg::KIND_END |-> tok.data.last_of_run)
		else $error("end token not last of its run");

	a_eos_resets: assert property (@(posedge clk) disable iff (!arst_n)
		fire && src.data.end_of_source |=> mode_q == air_pkg::MODE_IDLE && cur_off_q == '0)
		else $error("state not cleared after end of source");
`endif

endmodule
